// ===== design/recurrent_oscillator_step_top_macros.svh =====
// Assertion macros of the oscillator top level.
`ifndef RECURRENT_OSCILLATOR_STEP_TOP_MACROS_SVH
`define RECURRENT_OSCILLATOR_STEP_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define ROS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define ROS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ros_pkg.sv =====
// Types, constants and helper functions of the recurrent oscillator.
package ros_pkg;

  localparam int SIG_ENTRIES_DEF = 1024;
  localparam int ACT_W = 24;
  localparam int SIG_W = 16;
  localparam int ACC_W = 48;

  localparam logic signed [ACT_W-1:0] ACT_FIRST_INIT  = 24'sd13;
  localparam logic signed [ACT_W-1:0] ACT_SECOND_INIT = 24'sd197;

  localparam logic signed [ACT_W-1:0] WEIGHT_SELF_RST  = 24'sd281701;
  localparam logic signed [ACT_W-1:0] WEIGHT_CROSS_RST = 24'sd28264;
  localparam logic signed [ACT_W-1:0] OUT_GAIN_RST     = 24'sd1310720;
  localparam logic signed [ACT_W-1:0] OUT_OFFSET_RST   = -24'sd655360;

  // Table build: Taylor terms of e^-u, squarings, and divider lengths.
  localparam logic [3:0] TAYLOR_TERMS  = 4'd12;
  localparam logic [1:0] SQUARE_LAST   = 2'd3;
  localparam logic [4:0] DIV_TERM_BITS = 5'd29;
  localparam logic [4:0] DIV_SIG_BITS  = 5'd17;

  typedef enum logic [1:0] {
    REG_WEIGHT_SELF  = 2'd0,
    REG_WEIGHT_CROSS = 2'd1,
    REG_OUT_GAIN     = 2'd2,
    REG_OUT_OFFSET   = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_EXP_INIT,
    ST_TERM_MUL,
    ST_TERM_DIV,
    ST_EXP_DIFF,
    ST_SQUARE,
    ST_DIV_NEG,
    ST_DIV_NEG_RUN,
    ST_DIV_POS,
    ST_DIV_POS_RUN,
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_SECOND,
    ST_MAC_A1,
    ST_MAC_B1,
    ST_NEW_FIRST,
    ST_RD_NEW_FIRST,
    ST_MAC_A2,
    ST_MAC_B2,
    ST_NEW_SECOND,
    ST_RD_NEW_SECOND,
    ST_MUL_OUT,
    ST_NEW_OUT,
    ST_RD_OUT,
    ST_EMIT
  } ros_state_t;

  // Q7.32 sum to Q7.16: round half up, then clip to the 24-bit range.
  function automatic logic signed [ACT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [31:0]      q;
    v = acc + 48'sd32768;
    q = v[ACC_W-1:16];
    if (q > 32'sd8388607) begin
      round_sat = 24'sd8388607;
    end else if (q < -32'sd8388608) begin
      round_sat = -24'sd8388608;
    end else begin
      round_sat = q[ACT_W-1:0];
    end
  endfunction

endpackage

// ===== design/ros_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ros_ram import ros_pkg::*; #(
  parameter int WIDTH = SIG_W,
  parameter int DEPTH = SIG_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/recurrent_oscillator_step_top.sv =====
// Top level of the two-neuron recurrent oscillator with its sigmoid table.
// Each accepted input word advances two neurons (Q7.16) by one step and yields one
// output word with the sigmoids of both neurons and of the output neuron, all in
// Q0.16. After reset the block first builds its SIG_ENTRIES-entry sigmoid table in
// an on-chip RAM; the table is computed, not loaded, by the same multiplier and a
// radix-2 divider. in_ready stays low for the whole build, whereas configuration
// writes are taken throughout. Once the table is ready, a step runs from acceptance
// to the output word through a chain of five table reads, each with a registered RAM
// read, and five multiply or accumulate passes through the single 32 x 32 multiplier.
// One word is worked on at a time: in_ready is high only in the idle state, so a new
// input word is taken only after the previous step has finished. The output word is
// held in its own register, so a new input word is taken while the previous result
// still waits for out_ready. Configuration registers are written through cfg_we,
// cfg_index and cfg_data and should be changed only while no step is in progress.
// A set restart bit reloads the initial activities before the step is taken.
`include "recurrent_oscillator_step_top_macros.svh"

module recurrent_oscillator_step_top import ros_pkg::*; #(
  parameter int SIG_ENTRIES = SIG_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [ACT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             restart,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SIG_W-1:0] sig_first,
  output logic [SIG_W-1:0] sig_second,
  output logic [SIG_W-1:0] sig_output
);

  localparam int ADDR_W = $clog2(SIG_ENTRIES);
  localparam int NW     = $clog2(SIG_ENTRIES + 1);

  // Table cells are visited by distance from the centre; for an even table the
  // smallest distance is one half cell, for an odd table it is zero.
  localparam int      M0        = 1 - (SIG_ENTRIES % 2);
  localparam longint  SPAN_Q30  = 64'd1073741824;
  localparam longint  U_BASE    = (M0 * SPAN_Q30 / 2) / SIG_ENTRIES;
  localparam longint  UR_BASE   = (M0 * SPAN_Q30 / 2) % SIG_ENTRIES;
  localparam longint  U_STEP    = SPAN_Q30 / SIG_ENTRIES;
  localparam longint  UR_STEP   = SPAN_Q30 % SIG_ENTRIES;
  localparam int      KLO_BASE  = (SIG_ENTRIES - 1 - M0) / 2;
  localparam int      KHI_BASE  = (SIG_ENTRIES - 1 + M0) / 2;

  localparam logic [28:0]       U_INIT   = 29'(U_BASE);
  localparam logic [28:0]       U_INC    = 29'(U_STEP);
  localparam logic [NW-1:0]     UR_INIT  = NW'(UR_BASE);
  localparam logic [NW:0]       UR_INC   = (NW + 1)'(UR_STEP);
  localparam logic [NW:0]       N_EXT    = (NW + 1)'(SIG_ENTRIES);
  localparam logic [ADDR_W-1:0] KLO_INIT = ADDR_W'(KLO_BASE);
  localparam logic [ADDR_W-1:0] KHI_INIT = ADDR_W'(KHI_BASE);
  localparam logic [ADDR_W-1:0] K_LAST   = ADDR_W'(SIG_ENTRIES - 1);

  ros_state_t state, state_next;

  // Configuration registers.
  logic signed [ACT_W-1:0] weight_self, weight_cross, out_gain, out_offset;

  // Oscillator state and step datapath.
  logic signed [ACT_W-1:0] act_first, act_second, act_out;
  logic        [SIG_W-1:0] s_a, s_b, s_c, s_d;
  logic signed [ACC_W-1:0] acc;

  // Table build.
  logic [28:0]       u;
  logic [NW-1:0]     ur;
  logic [NW:0]       ur_sum;
  logic [ADDR_W-1:0] k_lo, k_hi;
  logic [30:0]       term;
  logic [31:0]       pos_sum, neg_sum;
  logic [3:0]        i_cnt;
  logic [30:0]       r_exp;
  logic [1:0]        sq_cnt;
  logic [31:0]       d_val;

  // Radix-2 restoring divider.
  logic [47:0] dv_rem, dv_ds;
  logic [28:0] dv_q;
  logic [4:0]  dv_cnt;
  logic        dv_done, dv_ge;

  // Shared multiplier.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  // Table RAM and lookup index.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [SIG_W-1:0]  ram_wdata, ram_rdata;
  logic signed [ACT_W-1:0] idx_x;
  logic [ACT_W-1:0]        x_off;
  logic [20+NW-1:0]        idx_prod;

  logic in_take, emit_go;

  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign dv_done = (dv_cnt == 5'd0);
  assign dv_ge   = (dv_rem >= dv_ds);
  assign d_val   = {1'b0, r_exp} + 32'h4000_0000;
  assign ur_sum  = {1'b0, ur} + UR_INC;
  assign in_take = in_valid && in_ready;
  assign emit_go = !out_valid || out_ready;

  ros_ram #(
    .WIDTH(SIG_W),
    .DEPTH(SIG_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_EXP_INIT:      state_next = ST_TERM_MUL;
      ST_TERM_MUL:      state_next = ST_TERM_DIV;
      ST_TERM_DIV: begin
        if (dv_done) begin
          state_next = (i_cnt == TAYLOR_TERMS) ? ST_EXP_DIFF : ST_TERM_MUL;
        end
      end
      ST_EXP_DIFF:      state_next = ST_SQUARE;
      ST_SQUARE: begin
        if (sq_cnt == SQUARE_LAST) begin
          state_next = ST_DIV_NEG;
        end
      end
      ST_DIV_NEG:       state_next = ST_DIV_NEG_RUN;
      ST_DIV_NEG_RUN: begin
        if (dv_done) begin
          state_next = ST_DIV_POS;
        end
      end
      ST_DIV_POS:       state_next = ST_DIV_POS_RUN;
      ST_DIV_POS_RUN: begin
        if (dv_done) begin
          state_next = (k_hi == K_LAST) ? ST_IDLE : ST_EXP_INIT;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RD_FIRST;
        end
      end
      ST_RD_FIRST:      state_next = ST_RD_SECOND;
      ST_RD_SECOND:     state_next = ST_MAC_A1;
      ST_MAC_A1:        state_next = ST_MAC_B1;
      ST_MAC_B1:        state_next = ST_NEW_FIRST;
      ST_NEW_FIRST:     state_next = ST_RD_NEW_FIRST;
      ST_RD_NEW_FIRST:  state_next = ST_MAC_A2;
      ST_MAC_A2:        state_next = ST_MAC_B2;
      ST_MAC_B2:        state_next = ST_NEW_SECOND;
      ST_NEW_SECOND:    state_next = ST_RD_NEW_SECOND;
      ST_RD_NEW_SECOND: state_next = ST_MUL_OUT;
      ST_MUL_OUT:       state_next = ST_NEW_OUT;
      ST_NEW_OUT:       state_next = ST_RD_OUT;
      ST_RD_OUT:        state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default:          state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier operands, table port controls.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_waddr = k_hi;
    ram_wdata = (dv_q[28:16] != 13'd0) ? 16'hFFFF : dv_q[15:0];
    unique case (state) inside
      ST_TERM_MUL: begin
        mul_a = {1'b0, term};
        mul_b = {3'b000, u};
      end
      ST_SQUARE: begin
        mul_a = {1'b0, r_exp};
        mul_b = {1'b0, r_exp};
      end
      ST_DIV_NEG_RUN: begin
        ram_we    = dv_done;
        ram_waddr = k_lo;
      end
      ST_DIV_POS_RUN: begin
        ram_we = dv_done;
      end
      ST_MAC_A1: begin
        mul_a = {{8{weight_self[ACT_W-1]}}, weight_self};
        mul_b = {16'h0000, s_a} - 32'h0000_8000;
      end
      ST_MAC_B1: begin
        mul_a = {{8{weight_cross[ACT_W-1]}}, weight_cross};
        mul_b = {16'h0000, s_b} - 32'h0000_8000;
      end
      ST_MAC_A2: begin
        mul_a = {{8{weight_self[ACT_W-1]}}, weight_self};
        mul_b = {16'h0000, s_b} - 32'h0000_8000;
      end
      ST_MAC_B2: begin
        mul_a = {{8{weight_cross[ACT_W-1]}}, weight_cross};
        mul_b = 32'h0000_8000 - {16'h0000, s_c};
      end
      ST_MUL_OUT: begin
        mul_a = {{8{out_gain[ACT_W-1]}}, out_gain};
        mul_b = {16'h0000, ram_rdata};
      end
      default: begin
      end
    endcase
    unique case (state) inside
      ST_RD_SECOND, ST_RD_NEW_SECOND: idx_x = act_second;
      ST_RD_OUT, ST_EMIT:             idx_x = act_out;
      default:                        idx_x = act_first;
    endcase
  end

  // Sigmoid index: clip outside [-8,8), else scale the offset argument.
  always_comb begin
    x_off    = idx_x + 24'sd524288;
    idx_prod = {{NW{1'b0}}, x_off[19:0]} * (20 + NW)'(SIG_ENTRIES);
    if (idx_x < -24'sd524288) begin
      ram_raddr = '0;
    end else if (idx_x >= 24'sd524288) begin
      ram_raddr = K_LAST;
    end else begin
      ram_raddr = idx_prod[20 +: ADDR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EXP_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_self  <= WEIGHT_SELF_RST;
      weight_cross <= WEIGHT_CROSS_RST;
      out_gain     <= OUT_GAIN_RST;
      out_offset   <= OUT_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WEIGHT_SELF:  weight_self  <= cfg_data;
        REG_WEIGHT_CROSS: weight_cross <= cfg_data;
        REG_OUT_GAIN:     out_gain     <= cfg_data;
        REG_OUT_OFFSET:   out_offset   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Neuron activities and the output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_first  <= ACT_FIRST_INIT;
      act_second <= ACT_SECOND_INIT;
      out_valid  <= 1'b0;
    end else begin
      if (in_take && restart) begin
        act_first  <= ACT_FIRST_INIT;
        act_second <= ACT_SECOND_INIT;
      end
      if (state == ST_NEW_FIRST) begin
        act_first <= round_sat(acc);
      end
      if (state == ST_NEW_SECOND) begin
        act_second <= round_sat(acc);
      end
      if (state == ST_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_go) begin
      sig_first  <= s_c;
      sig_second <= s_d;
      sig_output <= ram_rdata;
    end
  end

  // Step datapath: sigmoid captures and the accumulator.
  always_ff @(posedge clk) begin
    unique case (state) inside
      ST_RD_SECOND: s_a <= ram_rdata;
      ST_MAC_A1: begin
        s_b <= ram_rdata;
        acc <= prod[ACC_W-1:0];
      end
      ST_MAC_A2: begin
        s_c <= ram_rdata;
        acc <= prod[ACC_W-1:0];
      end
      ST_MAC_B1, ST_MAC_B2: acc <= acc + $signed(prod[ACC_W-1:0]);
      ST_MUL_OUT: begin
        s_d <= ram_rdata;
        acc <= prod[ACC_W-1:0];
      end
      ST_NEW_OUT: act_out <= round_sat(acc + {{8{out_offset[ACT_W-1]}}, out_offset, 16'h0000});
      default: begin
      end
    endcase
  end

  // Table build: cell walk, series for e^-u and the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      u      <= U_INIT;
      ur     <= UR_INIT;
      k_lo   <= KLO_INIT;
      k_hi   <= KHI_INIT;
      dv_cnt <= 5'd0;
    end else begin
      if (state == ST_TERM_MUL) begin
        dv_rem <= {19'd0, prod[58:30]};
        dv_ds  <= {16'd0, i_cnt, 28'd0};
        dv_q   <= '0;
        dv_cnt <= DIV_TERM_BITS;
      end else if (state == ST_DIV_NEG) begin
        dv_rem <= {1'b0, r_exp, 16'h0000} + {17'd0, d_val[31:1]};
        dv_ds  <= {d_val, 16'h0000};
        dv_q   <= '0;
        dv_cnt <= DIV_SIG_BITS;
      end else if (state == ST_DIV_POS) begin
        dv_rem <= 48'h4000_0000_0000 + {17'd0, d_val[31:1]};
        dv_ds  <= {d_val, 16'h0000};
        dv_q   <= '0;
        dv_cnt <= DIV_SIG_BITS;
      end else if (!dv_done) begin
        if (dv_ge) begin
          dv_rem <= dv_rem - dv_ds;
        end
        dv_q   <= {dv_q[27:0], dv_ge};
        dv_ds  <= {1'b0, dv_ds[47:1]};
        dv_cnt <= dv_cnt - 5'd1;
      end
      if (state == ST_DIV_POS_RUN && dv_done && k_hi != K_LAST) begin
        k_lo <= k_lo - 1'b1;
        k_hi <= k_hi + 1'b1;
        if (ur_sum >= N_EXT) begin
          u  <= u + U_INC + 29'd1;
          ur <= NW'(ur_sum - N_EXT);
        end else begin
          u  <= u + U_INC;
          ur <= ur_sum[NW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state) inside
      ST_EXP_INIT: begin
        term    <= 31'h4000_0000;
        pos_sum <= 32'h4000_0000;
        neg_sum <= '0;
        i_cnt   <= 4'd1;
      end
      ST_TERM_DIV: begin
        if (dv_done) begin
          term <= {2'b00, dv_q};
          if (i_cnt[0]) begin
            neg_sum <= neg_sum + {3'b000, dv_q};
          end else begin
            pos_sum <= pos_sum + {3'b000, dv_q};
          end
          i_cnt <= i_cnt + 4'd1;
        end
      end
      ST_EXP_DIFF: begin
        r_exp  <= 31'(pos_sum - neg_sum);
        sq_cnt <= '0;
      end
      ST_SQUARE: begin
        r_exp  <= prod[60:30];
        sq_cnt <= sq_cnt + 2'd1;
      end
      default: begin
      end
    endcase
  end

  `ROS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `ROS_ASSERT_IMP(a_table_write_before_use, ram_we, !out_valid, "table written after use")
  `ROS_ASSERT_IMP(a_sig_quotient_range, state == ST_DIV_POS_RUN && dv_done, dv_q <= 29'd65536, "sigmoid quotient out of range")
  `ROS_ASSERT_IMP(a_series_positive, state == ST_EXP_DIFF, pos_sum >= neg_sum, "negative series sum")
  `ROS_ASSERT_IMP(a_emit_source, $rose(out_valid), $past(state == ST_EMIT), "output word without step")

endmodule

// ===== tb/sv/recurrent_oscillator_step_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the recurrent oscillator: watches both channels, predicts every output word and compares it.
module recurrent_oscillator_step_checker import ros_pkg::*; #(
  parameter int SIG_N = SIG_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [ACT_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             restart,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [SIG_W-1:0] sig_first,
  input  logic [SIG_W-1:0] sig_second,
  input  logic [SIG_W-1:0] sig_output,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic [SIG_W-1:0] first;
    logic [SIG_W-1:0] second;
    logic [SIG_W-1:0] outn;
  } sig_triple_t;

  logic [SIG_W-1:0]        sig_lut [SIG_N];
  logic signed [ACT_W-1:0] w_self  = WEIGHT_SELF_RST;
  logic signed [ACT_W-1:0] w_cross = WEIGHT_CROSS_RST;
  logic signed [ACT_W-1:0] o_gain  = OUT_GAIN_RST;
  logic signed [ACT_W-1:0] o_bias  = OUT_OFFSET_RST;
  logic signed [ACT_W-1:0] n1_act  = ACT_FIRST_INIT;
  logic signed [ACT_W-1:0] n2_act  = ACT_SECOND_INIT;
  sig_triple_t             expected_words [$];

  // e^-16u in Q0.30: Taylor series of e^-(u), then raised to the 16th power by squaring.
  function automatic longint unsigned decay_q30(input longint unsigned u);
    longint unsigned term, pos, neg, r;
    term = 64'd1 << 30;
    pos  = term;
    neg  = 0;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * u) >> 30) / i;
      if (i % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    r = pos - neg;
    repeat (4) r = (r * r) >> 30;
    return r;
  endfunction

  // Sigmoid sampled at the centre of table cell k, rounded to Q0.16.
  function automatic logic [SIG_W-1:0] sigmoid_point(input int k);
    longint          c;
    longint unsigned mag, u, e, d, v;
    c   = 2 * k + 1 - SIG_N;
    mag = (c < 0) ? -c : c;
    u   = (mag << 29) / SIG_N;
    e   = decay_q30(u);
    d   = (64'd1 << 30) + e;
    if (c >= 0) begin
      v = ((64'd1 << 46) + d / 2) / d;
    end else begin
      v = ((e << 16) + d / 2) / d;
    end
    if (v > 65535) v = 65535;
    return v[SIG_W-1:0];
  endfunction

  function automatic logic [SIG_W-1:0] lut_read(input logic signed [ACT_W-1:0] x);
    longint xl, idx;
    xl = x;
    if (xl < -524288) begin
      idx = 0;
    end else if (xl >= 524288) begin
      idx = SIG_N - 1;
    end else begin
      idx = ((xl + 524288) * SIG_N) >>> 20;
    end
    if (idx < 0) idx = 0;
    if (idx > SIG_N - 1) idx = SIG_N - 1;
    return sig_lut[idx];
  endfunction

  // Q7.32 sum to Q7.16 with halves rounded upwards, clipped to 24 bits.
  function automatic logic signed [ACT_W-1:0] q716_round(input longint acc);
    longint q;
    q = (acc + 32768) >>> 16;
    if (q > 8388607) begin
      q = 8388607;
    end else if (q < -8388608) begin
      q = -8388608;
    end
    return q[ACT_W-1:0];
  endfunction

  // One oscillator step: the first neuron is updated first and the second one uses it.
  function automatic sig_triple_t advance_oscillator(input logic rs);
    longint                  a, b, g, p, s1_old, s2_old, s1, s2, acc;
    logic signed [ACT_W-1:0] o;
    sig_triple_t             w;
    a = w_self;
    b = w_cross;
    g = o_gain;
    p = o_bias;
    if (rs) begin
      n1_act = ACT_FIRST_INIT;
      n2_act = ACT_SECOND_INIT;
    end
    s1_old  = lut_read(n1_act);
    s2_old  = lut_read(n2_act);
    acc     = a * s1_old + b * s2_old - (a + b) * 32768;
    n1_act  = q716_round(acc);
    s1      = lut_read(n1_act);
    acc     = a * s2_old - b * s1 + (b - a) * 32768;
    n2_act  = q716_round(acc);
    s2      = lut_read(n2_act);
    o       = q716_round(g * s2 + p * 65536);
    w.first  = s1[SIG_W-1:0];
    w.second = s2[SIG_W-1:0];
    w.outn   = lut_read(o);
    return w;
  endfunction

  initial begin
    for (int k = 0; k < SIG_N; k++) sig_lut[k] = sigmoid_point(k);
  end

  always @(posedge clk) begin
    sig_triple_t got, want;
    if (rst) begin
      w_self  = WEIGHT_SELF_RST;
      w_cross = WEIGHT_CROSS_RST;
      o_gain  = OUT_GAIN_RST;
      o_bias  = OUT_OFFSET_RST;
      n1_act  = ACT_FIRST_INIT;
      n2_act  = ACT_SECOND_INIT;
      mismatches = 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{sig_first, sig_second, sig_output};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: output word %h %h %h arrived with none expected",
                     $realtime, got.first, got.second, got.outn);
          end
        end else begin
          want = expected_words.pop_front();
          if (got.first != want.first || got.second != want.second || got.outn != want.outn) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch first/second/output expected %h %h %h got %h %h %h",
                       $realtime, want.first, want.second, want.outn,
                       got.first, got.second, got.outn);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WEIGHT_SELF:  w_self  = cfg_data;
          REG_WEIGHT_CROSS: w_cross = cfg_data;
          REG_OUT_GAIN:     o_gain  = cfg_data;
          REG_OUT_OFFSET:   o_bias  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_words.push_back(advance_oscillator(restart));
    end
    pending = expected_words.size();
  end

endmodule

// ===== tb/sv/tb_recurrent_oscillator_step_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the recurrent oscillator: stimulus, idling and verdict around the scoreboard.
module tb_recurrent_oscillator_step_top;
  import ros_pkg::*;

  localparam int SIG_N = SIG_ENTRIES_DEF;
  // The table is built after reset with in_ready low, so the watchdog has to outlast
  // that quiet spell comfortably before it calls a hang.
  localparam int STALL_LIMIT = 700000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_WORDS = 50;

  localparam logic signed [ACT_W-1:0] Q_MAX   = 24'sh7FFFFF;
  localparam logic signed [ACT_W-1:0] Q_MIN   = 24'sh800000;
  // +8.0 in Q7.16: the upper edge of the sigmoid span.
  localparam logic signed [ACT_W-1:0] SPAN_HI = 24'sd524288;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [ACT_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic             restart;
  logic             out_valid;
  logic             out_ready;
  logic [SIG_W-1:0] sig_first;
  logic [SIG_W-1:0] sig_second;
  logic [SIG_W-1:0] sig_output;

  int mismatches;
  int pending;
  int idle_cycles = 0;

  // Shared between the stimulus and the receiver: calm switches idling off on both sides,
  // hold_req asks the receiver for one long hold-off.
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  recurrent_oscillator_step_top #(
    .SIG_ENTRIES(SIG_N)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sig_first (sig_first),
    .sig_second(sig_second),
    .sig_output(sig_output)
  );

  recurrent_oscillator_step_checker #(
    .SIG_N(SIG_N)
  ) osc_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sig_first (sig_first),
    .sig_second(sig_second),
    .sig_output(sig_output),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Receiver. It refuses about one cycle in three, never while calm is set, and on request
  // holds out_ready low for a long stretch that it counts itself. During that stretch the
  // block fills its output register and its working step, so in_ready must drop.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** recurrent_oscillator_step_top: FAILED **");
      $finish;
    end
  end

  // Offers one stepping word. The sender idles about one cycle in three beforehand (with a
  // random restart bit as noise while valid is low), then holds valid and the payload until
  // the word is taken. It returns just after the accepting edge with valid still high, so
  // the next call either lowers it or replaces the payload, never both in one step.
  task automatic offer_word(input logic rs);
    while (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [ACT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  // The sender pauses until every predicted word has come back. Each stepping word yields
  // exactly one output word, so once the count is zero the block is idle and may be
  // reconfigured at the next edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // One phase: load all four registers while idle, send n words, then drain. The first word
  // carries lead_restart; the others restart with the given chance in percent.
  task automatic run_phase(input logic [ACT_W-1:0] ws, wc, gain, bias,
                           input int n, input bit lead_restart, input int restart_pct);
    write_reg(REG_WEIGHT_SELF, ws);
    write_reg(REG_WEIGHT_CROSS, wc);
    write_reg(REG_OUT_GAIN, gain);
    write_reg(REG_OUT_OFFSET, bias);
    cfg_we <= 1'b0;
    for (int i = 0; i < n; i++) begin
      offer_word(i == 0 ? lead_restart : ($urandom_range(0, 99) < restart_pct));
    end
    drain();
  endtask

  initial begin
    logic [ACT_W-1:0] ws, wc, gain, bias;
    bit               lifelike;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_WEIGHT_SELF;
    cfg_data  = '0;
    in_valid  = 1'b0;
    restart   = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first phase also sits through the table build, as the first word
    // is not taken until the table is ready. Default weights: a restart, a short run of the
    // oscillator, then a restart in the middle of the motion.
    run_phase(WEIGHT_SELF_RST, WEIGHT_CROSS_RST, OUT_GAIN_RST, OUT_OFFSET_RST, 7, 1'b1, 0);
    run_phase(WEIGHT_SELF_RST, WEIGHT_CROSS_RST, OUT_GAIN_RST, OUT_OFFSET_RST, 2, 1'b1, 0);
    // Extreme weights drive sums past the Q7.16 limits and sigmoid arguments outside
    // their span, in both directions.
    run_phase(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 2, 1'b1, 0);
    run_phase(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 3, 1'b0, 0);
    run_phase(Q_MAX, Q_MIN, '0, '0, 3, 1'b0, 0);
    // Zero weights put both neurons exactly at zero, the centre of the table.
    run_phase('0, '0, Q_MIN, Q_MAX, 2, 1'b1, 0);
    // With no gain the output neuron equals the bias, so the bias probes the table edges:
    // just below -8, exactly -8, just below +8 and exactly +8.
    run_phase(WEIGHT_SELF_RST, WEIGHT_CROSS_RST, '0, -SPAN_HI - 24'sd1, 1, 1'b0, 0);
    run_phase(WEIGHT_SELF_RST, WEIGHT_CROSS_RST, '0, -SPAN_HI, 1, 1'b0, 0);
    run_phase(WEIGHT_SELF_RST, WEIGHT_CROSS_RST, '0, SPAN_HI - 24'sd1, 1, 1'b0, 0);
    run_phase(WEIGHT_SELF_RST, WEIGHT_CROSS_RST, '0, SPAN_HI, 1, 1'b0, 0);

    // Random part. Most phases use weights of a working oscillator (self weight between
    // about three and six, small cross weight) and rarely restart, so the neurons run through long
    // trajectories. Every third phase takes arbitrary 24-bit weights and restarts often.
    for (int p = 0; p < 12; p++) begin
      lifelike = (p % 3 != 2);
      calm     = (p == 4);
      if (p == 2) hold_req = 1'b1;
      if (lifelike) begin
        ws   = 24'(200000 + $urandom_range(0, 200000));
        wc   = 24'($urandom_range(0, 200000) - 100000);
        gain = 24'($urandom_range(0, 2000000));
        bias = 24'(0 - $urandom_range(0, 1500000));
      end else begin
        ws   = 24'($urandom);
        wc   = 24'($urandom);
        gain = 24'($urandom);
        bias = 24'($urandom);
      end
      run_phase(ws, wc, gain, bias, PHASE_WORDS, 1'($urandom_range(0, 1)),
                lifelike ? 2 : 30);
    end
    calm = 1'b0;

    // Let any stray output word show itself before the verdict.
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** recurrent_oscillator_step_top: PASSED **");
    end else begin
      $display("** recurrent_oscillator_step_top: FAILED **");
    end
    $finish;
  end

endmodule
